>>> hw/rtl/est_pkg.sv
// shared types and constants for the encoder scan trigger
// used by every module of the block, no dependencies
package est_pkg;

  localparam int CNT_W      = 32;  // encoder counter width
  localparam int POS_W      = 33;  // exact signed position
  localparam int DIST_W     = 35;  // signed distance between two positions
  localparam int DIV_W      = 34;  // magnitude of a distance, divider dividend
  localparam int STEP_W     = 16;
  localparam int COL_W      = 16;
  localparam int CHK_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int DEF_COLUMN_LIMIT = 65535;
  localparam int DEF_QUEUE_DEPTH  = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLITCH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK   = 2'd3;

  localparam logic [STEP_W-1:0] RST_STEP   = 16'd10;
  localparam logic [CNT_W-1:0]  RST_GLITCH = 32'd10000;
  localparam logic [CHK_W-1:0]  RST_CHECK  = 8'd100;

  typedef struct packed {
    logic              reverse;
    logic [STEP_W-1:0] step;     // never zero
    logic [CNT_W-1:0]  glitch;
    logic [CHK_W-1:0]  check;
  } cfg_t;

  typedef struct packed {
    logic                    restart;
    logic [CNT_W-1:0]        mag;   // |a - b|
    logic signed [POS_W-1:0] diff;  // a - b
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0]  position;
    logic [STEP_W-1:0] step_count;
    logic              step_backward;
    logic [COL_W-1:0]  column;
    logic              rejected;
  } res_t;

endpackage

>>> hw/rtl/est_front.sv
// front stage: takes encoder words, drops invalid frames, forms a - b and |a - b|
// depends on est_pkg
module est_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [63:0]           in_tdata,   // count_a, count_b
  input  logic [1:0]            in_tuser,   // frame_valid, restart
  output logic                  q_valid,
  input  logic                  q_ready,
  output est_pkg::item_t        q_item
);

  logic                           valid_r;
  est_pkg::item_t                 item_r;
  logic [est_pkg::CNT_W-1:0]      cnt_a;
  logic [est_pkg::CNT_W-1:0]      cnt_b;
  logic signed [est_pkg::POS_W-1:0] diff;
  logic signed [est_pkg::POS_W-1:0] neg_diff;

  assign cnt_a    = in_tdata[31:0];
  assign cnt_b    = in_tdata[63:32];
  assign diff     = $signed({1'b0, cnt_a}) - $signed({1'b0, cnt_b});
  assign neg_diff = -diff;

  assign in_tready = !valid_r || q_ready;
  assign q_valid   = valid_r;
  assign q_item    = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      // a frame with frame_valid low leaves no trace
      valid_r <= in_tvalid && in_tuser[0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.restart <= in_tuser[1];
      item_r.diff    <= diff;
      item_r.mag     <= diff[est_pkg::POS_W-1] ? neg_diff[est_pkg::CNT_W-1:0]
                                               : diff[est_pkg::CNT_W-1:0];
    end
  end

endmodule

>>> hw/rtl/est_queue.sv
// small fifo between the front stage and the step engine
// depends on est_pkg
module est_queue #(
  parameter int DEPTH = est_pkg::DEF_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  est_pkg::item_t wr_item,
  output logic           rd_valid,
  input  logic           rd_ready,
  output est_pkg::item_t rd_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  est_pkg::item_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;

  assign wr_ready = count_r != CNT_W'(DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_item  = mem[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

endmodule

>>> hw/rtl/est_div.sv
// restoring divider, one quotient bit per cycle
// depends on est_pkg
module est_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [est_pkg::DIV_W-1:0]  dividend,
  input  logic [est_pkg::STEP_W-1:0] divisor,
  output logic                       done,
  output logic [est_pkg::DIV_W-1:0]  quotient,
  output logic [est_pkg::STEP_W-1:0] remainder
);

  localparam int DW = est_pkg::DIV_W;
  localparam int SW = est_pkg::STEP_W;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_r, quo_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] dvs_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [SW+1:0] trial;
  logic          borrow;

  // shift in the next dividend bit and try the subtract
  assign trial  = {1'b0, rem_r, quo_r[DW-1]} - {2'b00, dvs_r};
  assign borrow = trial[SW+1];

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CW'(DW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      quo_nxt = {quo_r[DW-2:0], !borrow};
      rem_nxt = borrow ? {rem_r[SW-2:0], quo_r[DW-1]} : trial[SW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

>>> hw/rtl/est_back.sv
// step engine: glitch check, trigger point tracking and column update, result register
// depends on est_pkg and est_div
module est_back #(
  parameter int COLUMN_LIMIT = est_pkg::DEF_COLUMN_LIMIT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  est_pkg::cfg_t  cfg,
  input  logic           q_valid,
  output logic           q_ready,
  input  est_pkg::item_t q_item,
  output logic           res_valid,
  input  logic           res_ready,
  output est_pkg::res_t  res
);

  localparam int PW = est_pkg::POS_W;
  localparam int DW = est_pkg::DIST_W;
  localparam int QW = est_pkg::DIV_W;
  localparam int SW = est_pkg::STEP_W;
  localparam int CW = est_pkg::COL_W;
  localparam int KW = est_pkg::CHK_W;

  localparam logic [CW-1:0] LIM = (COLUMN_LIMIT > 65535) ? {CW{1'b1}} : CW'(COLUMN_LIMIT);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVAL  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_APPLY = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic                 first_r, first_nxt;
  logic [KW-1:0]        checked_r, checked_nxt;
  logic signed [PW-1:0] tp_r, tp_nxt;
  logic [CW-1:0]        col_r, col_nxt;
  logic signed [PW-1:0] pos_r, pos_nxt;
  logic                 fwd_r, fwd_nxt;
  est_pkg::res_t        stage_r, stage_nxt;
  est_pkg::res_t        out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 cur_first;
  logic [KW-1:0]        cur_checked;
  logic signed [PW-1:0] cur_tp;
  logic [CW-1:0]        cur_col;
  logic                 checking;
  logic signed [DW-1:0] fdist;
  logic signed [DW-1:0] ndist;
  logic signed [DW-1:0] step_s;
  logic [CW-1:0]        room;
  logic                 div_start;
  logic [QW-1:0]        div_dividend;
  logic                 div_done;
  logic [QW-1:0]        quo;
  logic [SW-1:0]        rem;

  est_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (cfg.step),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  // restart clears the scan before the frame is looked at
  assign cur_first   = q_item.restart || first_r;
  assign cur_checked = q_item.restart ? '0 : checked_r;
  assign cur_tp      = q_item.restart ? '0 : tp_r;
  assign cur_col     = q_item.restart ? '0 : col_r;
  assign checking    = cur_checked < cfg.check;

  assign fdist  = DW'(pos_r) - DW'(tp_r);
  assign ndist  = DW'(tp_r) - DW'(pos_r);
  assign step_s = $signed({{(DW-SW){1'b0}}, cfg.step});
  assign room   = (col_r >= LIM) ? '0 : LIM - col_r;

  always_comb begin
    state_nxt     = state_r;
    first_nxt     = first_r;
    checked_nxt   = checked_r;
    tp_nxt        = tp_r;
    col_nxt       = col_r;
    pos_nxt       = pos_r;
    fwd_nxt       = fwd_r;
    stage_nxt     = stage_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !res_ready;
    q_ready       = 1'b0;
    div_start     = 1'b0;
    div_dividend  = fdist[QW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_ready     = 1'b1;
          first_nxt   = cur_first;
          checked_nxt = cur_checked;
          tp_nxt      = cur_tp;
          col_nxt     = cur_col;
          pos_nxt     = cfg.reverse ? -q_item.diff : q_item.diff;
          stage_nxt.position      = '0;
          stage_nxt.step_count    = '0;
          stage_nxt.step_backward = 1'b0;
          stage_nxt.column        = cur_col;
          stage_nxt.rejected      = 1'b0;
          if (cur_first) begin
            first_nxt = 1'b0;
            state_nxt = ST_DONE;
          end else if (checking && (q_item.mag > cfg.glitch)) begin
            stage_nxt.rejected = 1'b1;
            state_nxt          = ST_DONE;
          end else begin
            if (checking) begin
              checked_nxt = cur_checked + 1'b1;
            end
            state_nxt = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        stage_nxt.position = pos_r[est_pkg::CNT_W-1:0];
        if (fdist >= step_s) begin
          fwd_nxt      = 1'b1;
          div_start    = 1'b1;
          div_dividend = fdist[QW-1:0];
          state_nxt    = ST_DIV;
        end else if ((ndist >= step_s) && (col_r != '0)) begin
          fwd_nxt      = 1'b0;
          div_start    = 1'b1;
          div_dividend = ndist[QW-1:0];
          state_nxt    = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (fwd_r) begin
          // column holds at its limit, step count still shows every step up to its all-ones maximum
          col_nxt = col_r + ((quo > QW'(room)) ? room : quo[CW-1:0]);
          stage_nxt.step_count = (quo > QW'({SW{1'b1}})) ? {SW{1'b1}} : quo[SW-1:0];
          tp_nxt  = pos_r - $signed({{(PW-SW){1'b0}}, rem});
        end else begin
          col_nxt = col_r - ((quo > QW'(col_r)) ? col_r : quo[CW-1:0]);
          stage_nxt.step_count = (quo > QW'(col_r)) ? col_r : quo[SW-1:0];
          stage_nxt.step_backward = 1'b1;
          tp_nxt  = pos_r + $signed({{(PW-SW){1'b0}}, rem});
        end
        stage_nxt.column = col_nxt;
        state_nxt        = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || res_ready) begin
          out_nxt       = stage_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      first_r     <= 1'b1;
      checked_r   <= '0;
      tp_r        <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      checked_r   <= checked_nxt;
      tp_r        <= tp_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    fwd_r   <= fwd_nxt;
    stage_r <= stage_nxt;
    out_r   <= out_nxt;
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

endmodule

>>> hw/rtl/encoder_scan_trigger.sv
// top level of the encoder scan trigger: configuration registers and the three stages
// depends on est_pkg, est_front, est_queue, est_back
//
//   port group | dir | carries
//   in_*       | in  | encoder counters a and b, frame_valid and restart flags
//   out_*      | out | position, step count, column, step_backward and rejected flags
//   cfg_*      | in  | register writes, no read-back
//
// in the step engine a first or rejected frame goes from idle straight to done, one
// that takes no step passes through eval, and one that moves the trigger point also
// waits in div on the bit-serial divider, then reaches apply; while the queue has
// room, the front stage and the queue keep taking words while the engine works and
// while a result waits on out_tready; reset is synchronous and clears the scan state
// and the registers to their defaults; frames with frame_valid low produce nothing
module encoder_scan_trigger #(
  parameter int COLUMN_LIMIT = est_pkg::DEF_COLUMN_LIMIT,
  parameter int QUEUE_DEPTH  = est_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [63:0]                    in_tdata,   // count_a, count_b
  input  logic [1:0]                     in_tuser,   // frame_valid, restart
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [63:0]                    out_tdata,  // position, step_count, column
  output logic [1:0]                     out_tuser,  // step_backward, rejected
  input  logic                           cfg_we,
  input  logic [est_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [est_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  est_pkg::cfg_t  cfg_r;
  logic           f_valid;
  logic           f_ready;
  est_pkg::item_t f_item;
  logic           q_valid;
  logic           q_ready;
  est_pkg::item_t q_item;
  est_pkg::res_t  res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reverse <= 1'b0;
      cfg_r.step    <= est_pkg::RST_STEP;
      cfg_r.glitch  <= est_pkg::RST_GLITCH;
      cfg_r.check   <= est_pkg::RST_CHECK;
    end else if (cfg_we) begin
      unique case (cfg_index)
        est_pkg::REG_REVERSE: cfg_r.reverse <= cfg_wdata[0];
        // a step size of zero counts as one
        est_pkg::REG_STEP:    cfg_r.step    <= (cfg_wdata[est_pkg::STEP_W-1:0] == '0) ?
                                               est_pkg::STEP_W'(1) :
                                               cfg_wdata[est_pkg::STEP_W-1:0];
        est_pkg::REG_GLITCH:  cfg_r.glitch  <= cfg_wdata[est_pkg::CNT_W-1:0];
        est_pkg::REG_CHECK:   cfg_r.check   <= cfg_wdata[est_pkg::CHK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  est_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .q_item    (f_item)
  );

  est_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  est_back #(
    .COLUMN_LIMIT (COLUMN_LIMIT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {res.column, res.step_count, res.position};
  assign out_tuser = {res.rejected, res.step_backward};

endmodule

>>> tb/scan_trigger_checker.sv
// checker for the encoder scan trigger: watches the in, out and cfg ports,
// predicts every result word and compares it field by field
// depends on est_pkg only
module scan_trigger_checker #(
  parameter int COLUMN_LIMIT = est_pkg::DEF_COLUMN_LIMIT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [63:0]                    in_tdata,   // count_a, count_b
  input  logic [1:0]                     in_tuser,   // frame_valid, restart
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [63:0]                    out_tdata,  // position, step_count, column
  input  logic [1:0]                     out_tuser,  // step_backward, rejected
  input  logic                           cfg_we,
  input  logic [est_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [est_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             reports_due,
  output int                             reports_checked,
  output int                             rejects_seen,
  output int                             backward_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import est_pkg::*;

  localparam longint COL_MAX = (COLUMN_LIMIT > 65535) ? 65535 : COLUMN_LIMIT;

  // register copies
  logic        dir_reverse;
  logic [15:0] counts_per_step;
  longint      glitch_lim;
  int          frames_to_check;

  // scan state
  logic   first_pending;
  int     frames_checked;
  longint trigger_pos;
  longint scan_col;

  res_t frame_reports_q[$];
  int   n_bad, n_checked, n_rejects, n_backward;

  function automatic res_t advance_scan(logic [31:0] a, logic [31:0] b, logic restart);
    res_t   r;
    longint sa, sb, d, mag, pos, stride, span, n, room, dec;
    r = '0;
    sa = {32'd0, a};
    sb = {32'd0, b};
    if (restart) begin
      first_pending = 1'b1;
      frames_checked = 0;
      trigger_pos = 0;
      scan_col = 0;
    end
    if (first_pending) begin
      first_pending = 1'b0;
      r.column = scan_col[15:0];
      return r;
    end
    // glitch screening always looks at a - b, whatever the direction
    if (frames_checked < frames_to_check) begin
      d = sa - sb;
      mag = (d < 0) ? -d : d;
      if (mag > glitch_lim) begin
        r.column = scan_col[15:0];
        r.rejected = 1'b1;
        return r;
      end
      frames_checked = (frames_checked + 1) & 8'hFF;
    end
    pos = dir_reverse ? (sb - sa) : (sa - sb);
    stride = (counts_per_step == 16'd0) ? 1 : {48'd0, counts_per_step};
    if (pos >= trigger_pos + stride) begin
      span = pos - trigger_pos;
      n = span / stride;
      room = (scan_col >= COL_MAX) ? 0 : COL_MAX - scan_col;
      scan_col += (n > room) ? room : n;
      r.step_count = (n > 65535) ? 16'hFFFF : n[15:0];
      trigger_pos = pos - span % stride;
    end else if (trigger_pos - pos >= stride && scan_col > 0) begin
      span = trigger_pos - pos;
      n = span / stride;
      dec = (n > scan_col) ? scan_col : n;
      scan_col -= dec;
      r.step_count = dec[15:0];
      r.step_backward = 1'b1;
      trigger_pos = pos + span % stride;
    end
    r.position = pos[31:0];
    r.column = scan_col[15:0];
    return r;
  endfunction

  task automatic flag_field(string field, logic [31:0] want, logic [31:0] got);
    n_bad++;
    if (n_bad <= 10)
      $display("%0t mismatch on %s: expected %h, got %h", $realtime, field, want, got);
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      dir_reverse = 1'b0;
      counts_per_step = RST_STEP;
      glitch_lim = {32'd0, RST_GLITCH};
      frames_to_check = RST_CHECK;
      first_pending = 1'b1;
      frames_checked = 0;
      trigger_pos = 0;
      scan_col = 0;
      frame_reports_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_REVERSE: dir_reverse = cfg_wdata[0];
          REG_STEP:    counts_per_step = cfg_wdata[15:0];
          REG_GLITCH:  glitch_lim = {32'd0, cfg_wdata};
          REG_CHECK:   frames_to_check = cfg_wdata[7:0];
          default: ;
        endcase
      end
      // words with frame_valid low leave no trace, restart included
      if (in_tvalid && in_tready && in_tuser[0])
        frame_reports_q.push_back(advance_scan(in_tdata[31:0], in_tdata[63:32], in_tuser[1]));
      if (out_tvalid && out_tready) begin
        n_checked++;
        if (out_tuser[1]) n_rejects++;
        if (out_tuser[0]) n_backward++;
        if (frame_reports_q.size() == 0) begin
          flag_field("unexpected result word", 32'd0, out_tdata[31:0]);
        end else begin
          want = frame_reports_q.pop_front();
          if (out_tdata[31:0] !== want.position)
            flag_field("position", want.position, out_tdata[31:0]);
          if (out_tdata[47:32] !== want.step_count)
            flag_field("step_count", want.step_count, out_tdata[47:32]);
          if (out_tdata[63:48] !== want.column)
            flag_field("column", want.column, out_tdata[63:48]);
          if (out_tuser[0] !== want.step_backward)
            flag_field("step_backward", want.step_backward, out_tuser[0]);
          if (out_tuser[1] !== want.rejected)
            flag_field("rejected", want.rejected, out_tuser[1]);
        end
      end
    end
    mismatches <= n_bad;
    reports_due <= frame_reports_q.size();
    reports_checked <= n_checked;
    rejects_seen <= n_rejects;
    backward_seen <= n_backward;
  end

endmodule

>>> tb/testbench.sv
// top of the encoder scan trigger testbench: clock, reset, frame and config stimulus
// depends on est_pkg, encoder_scan_trigger and scan_trigger_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import est_pkg::*;

  localparam int     COL_LIMIT   = DEF_COLUMN_LIMIT;
  localparam int     SETTLE      = 100;   // idle tail of each drain, after the last result word
  localparam int     HOLD_CYCLES = 400;
  localparam int     PHASE_WORDS = 125;
  localparam longint COUNT_MAX   = 64'h0000_0000_FFFF_FFFF;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [63:0]           in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [63:0]           out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int mismatches, reports_due, reports_checked, rejects_seen, backward_seen;

  bit     hold_go, hold_active, no_gaps;
  longint cur_step;
  int     frames_sent, frames_ignored;

  encoder_scan_trigger #(.COLUMN_LIMIT(COL_LIMIT)) DUT (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  scan_trigger_checker #(.COLUMN_LIMIT(COL_LIMIT)) u_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_we, .cfg_index, .cfg_wdata,
    .mismatches, .reports_due, .reports_checked, .rejects_seen, .backward_seen
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint clamp_count(longint v);
    return (v < 0) ? 0 : ((v > COUNT_MAX) ? COUNT_MAX : v);
  endfunction

  // leaves in_tvalid high after the accepting edge, so back-to-back words need no toggle
  task automatic send_frame(logic [31:0] a, logic [31:0] b, logic fv, logic rs);
    int gap, pick;
    gap = 0;
    if (!no_gaps) begin
      pick = $urandom_range(0, 99);
      if (pick >= 93) gap = $urandom_range(8, 40);
      else if (pick >= 65) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {b, a};
    in_tuser <= {rs, fv};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    frames_sent++;
    if (!fv) frames_ignored++;
  endtask

  task automatic drain(int extra);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic cfg_set(logic rev, logic [15:0] stride, logic [31:0] glitch, logic [7:0] chk);
    cfg_we <= 1'b1;
    cfg_index <= REG_REVERSE;
    cfg_wdata <= {31'd0, rev};
    @(posedge clk);
    cfg_index <= REG_STEP;
    cfg_wdata <= {16'd0, stride};
    @(posedge clk);
    cfg_index <= REG_GLITCH;
    cfg_wdata <= glitch;
    @(posedge clk);
    cfg_index <= REG_CHECK;
    cfg_wdata <= {24'd0, chk};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_step = (stride == 16'd0) ? 1 : stride;
  endtask

  // mostly scans that start with a restart and walk smoothly, with noise mixed in
  task automatic run_phase(int frames, bit with_hold);
    longint ca, cb, jump;
    int     done, scan_left, pick, burst_left;
    done = 0;
    scan_left = 0;
    burst_left = 0;
    while (done < frames) begin
      if (with_hold && done == 10 && !hold_go) begin
        hold_go = 1'b1;
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (!hold_active) @(posedge clk);
        burst_left = 20;
      end
      no_gaps = (burst_left > 0) || no_gaps;
      if (scan_left == 0) begin
        scan_left = $urandom_range(8, 60);
        if (burst_left == 0) no_gaps = ($urandom_range(0, 3) == 0);
        ca = $urandom;
        cb = clamp_count(ca + $urandom_range(0, 40) - 20);
        send_frame(ca[31:0], cb[31:0], 1'b1, 1'b1);
        done++;
        scan_left--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          send_frame($urandom, $urandom, 1'b0, 1'($urandom_range(0, 1)));
        end else if (pick < 8) begin
          send_frame($urandom, $urandom, 1'b1, 1'($urandom_range(0, 3) == 0));
          done++;
        end else if (pick < 12) begin
          // a lone spike on counter a; the walk carries on afterwards
          jump = clamp_count(ca + $urandom_range(32'h0010_0000, 32'h8000_0000));
          send_frame(jump[31:0], cb[31:0], 1'b1, 1'b0);
          done++;
        end else begin
          if (pick < 20)
            jump = longint'($urandom_range(0, 2_097_152)) - 1_048_576;
          else
            jump = longint'($urandom_range(0, 9 * cur_step)) - 4 * cur_step;
          ca = clamp_count(ca + jump);
          cb = clamp_count(cb + $urandom_range(0, 4) - 2);
          send_frame(ca[31:0], cb[31:0], 1'b1, 1'b0);
          done++;
        end
        scan_left--;
        if ($urandom_range(0, 39) == 0) drain(0);
      end
      if (burst_left > 0) begin
        burst_left--;
        if (burst_left == 0) no_gaps = 1'b0;
      end
    end
  endtask

  initial begin : receiver
    int run_len, pick;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_go && !hold_active) begin
        hold_active = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          out_tready <= 1'b1;
          run_len = $urandom_range(1, 60);
        end else if (pick < 90) begin
          out_tready <= 1'b0;
          run_len = $urandom_range(1, 3);
        end else begin
          out_tready <= 1'b0;
          run_len = $urandom_range(10, 60);
        end
        repeat (run_len) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int waited, ph;
    logic [15:0] stride;
    logic [31:0] glitch;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = REG_REVERSE;
    cfg_wdata = '0;
    cur_step = RST_STEP;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: first frame, steps both ways, blocked backward, glitch screen
    send_frame(32'd5, 32'd0, 1'b1, 1'b0);
    send_frame(32'd25, 32'd0, 1'b1, 1'b0);
    send_frame(32'd0, 32'd0, 1'b1, 1'b0);
    send_frame(32'd0, 32'd15, 1'b1, 1'b0);
    send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
    send_frame(32'd20000, 32'd0, 1'b1, 1'b0);
    send_frame(32'd0, 32'd20000, 1'b1, 1'b0);
    send_frame(32'd10000, 32'd0, 1'b1, 1'b0);
    send_frame(32'd12345, 32'd0, 1'b1, 1'b1);
    drain(SETTLE);

    // reversed, zero step, no screening: full-range swings and column saturation
    cfg_set(1'b1, 16'd0, 32'hFFFF_FFFF, 8'd0);
    send_frame(32'd0, 32'd0, 1'b1, 1'b1);
    send_frame(32'hFFFF_FFFF, 32'd0, 1'b1, 1'b0);
    send_frame(32'd0, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_frame(32'hFFFF_FFFF, 32'd0, 1'b1, 1'b0);
    send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    drain(SETTLE);

    // largest step, zero glitch limit, longest screening
    cfg_set(1'b0, 16'hFFFF, 32'd0, 8'hFF);
    send_frame(32'd7, 32'd7, 1'b1, 1'b1);
    send_frame(32'd5, 32'd5, 1'b1, 1'b0);
    send_frame(32'd6, 32'd5, 1'b1, 1'b0);
    send_frame(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0);
    drain(SETTLE);

    // one screened frame, then screening is over
    cfg_set(1'b0, 16'd1, 32'd100, 8'd1);
    send_frame(32'd0, 32'd0, 1'b1, 1'b1);
    send_frame(32'd100, 32'd0, 1'b1, 1'b0);
    send_frame(32'd500, 32'd0, 1'b1, 1'b0);
    drain(SETTLE);

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: cfg_set(1'b0, RST_STEP, RST_GLITCH, RST_CHECK);
        1: cfg_set(1'b1, 16'd1, 32'hFFFF_FFFF, 8'd0);
        2: cfg_set(1'b0, 16'hFFFF, 32'h0010_0000, 8'hFF);
        3: cfg_set(1'b1, 16'd0, 32'd5000, 8'd20);
        default: begin
          if ($urandom_range(0, 99) < 60) stride = $urandom_range(1, 40);
          else stride = $urandom_range(0, 65535);
          if ($urandom_range(0, 1) == 0) glitch = $urandom;
          else glitch = $urandom_range(100, 1_000_000);
          cfg_set(1'($urandom_range(0, 1)), stride, glitch, 8'($urandom_range(0, 255)));
        end
      endcase
      run_phase(PHASE_WORDS, ph == 1);
      no_gaps = 1'b0;
      drain(SETTLE);
    end

    waited = 0;
    while (reports_due != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);

    $display("sent %0d frame words (%0d with frame_valid low) over 10 register settings",
             frames_sent, frames_ignored);
    $display("checked %0d result words: %0d rejected, %0d with backward steps",
             reports_checked, rejects_seen, backward_seen);
    if (mismatches == 0 && reports_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
